@@ design/sps_pkg.sv @@
`timescale 1ns / 1ps

package sps_pkg;

  // Table size and field widths
  localparam int NUM_SLOTS  = 5;
  localparam int NUM_PINS   = 32;
  localparam int SLOT_W     = 3;
  localparam int PIN_W      = 5;
  localparam int MASK_W     = 32;
  localparam int CNT_W      = 8;
  localparam int CMD_W      = 2;
  localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PIN_IDX_W  = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam logic [CNT_W-1:0] STEP_RESET = CNT_W'(20);

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_SLEEP  = 2'd2,
    CMD_WAKE   = 2'd3
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch request, restart walk
    logic apply;      // execute create / sleep / wake
    logic walk_step;  // examine one slot of a pick
    logic finish;     // commit the starvation winner, or clear the current slot
    logic load_out;   // move current selection into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_pick;
    logic early;      // walked slot was woken or elite
    logic last;       // walked slot is the final one
  } dp_stat_t;

endpackage

@@ design/sps_ctrl.sv @@
`timescale 1ns / 1ps

module sps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sps_pkg::dp_stat_t stat_i,
  output sps_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WALK  = 5'b00100,
    S_FINAL = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        state_d = stat_i.is_pick ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (stat_i.early)     state_d = S_DONE;
        else if (stat_i.last) state_d = S_FINAL;
      end
      S_FINAL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.apply     = (state_q == S_START) && !stat_i.is_pick;
    cmd_o.walk_step = (state_q == S_WALK);
    cmd_o.finish    = (state_q == S_FINAL);
    cmd_o.load_out  = (state_q == S_DONE) && out_free;
  end

  // Output valid: set on load, dropped once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)    out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/sps_dp.sv @@
`timescale 1ns / 1ps

module sps_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sps_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [sps_pkg::CMD_W-1:0]         command_i,
  input  logic [sps_pkg::SLOT_W-1:0]        slot_i,
  input  logic                              elite_request_i,
  input  logic [sps_pkg::PIN_W-1:0]         pin_i,
  input  logic [sps_pkg::MASK_W-1:0]        wanted_mask_i,
  input  logic [sps_pkg::MASK_W-1:0]        changed_mask_i,
  input  sps_pkg::dp_cmd_t                  cmd_i,
  output sps_pkg::dp_stat_t                 stat_o,
  output logic                              selected_valid_o,
  output logic [sps_pkg::SLOT_W-1:0]        selected_slot_o,
  output logic                              woken_o
);

  localparam int NS = sps_pkg::NUM_SLOTS;
  localparam int NP = sps_pkg::NUM_PINS;
  localparam int IW = sps_pkg::IDX_W;
  localparam int SW = sps_pkg::SLOT_W;
  localparam int CW = sps_pkg::CNT_W;
  localparam int PW = sps_pkg::PIN_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NS - 1);

  // Latched request
  sps_pkg::cmd_e  cmd_q;
  logic [SW-1:0]  slot_q;
  logic           elite_req_q;
  logic [PW-1:0]  pin_q;
  logic [NP-1:0]  fired_q;

  // Slot table
  logic [NS-1:0]  active_q;
  logic [NS-1:0]  elite_q;
  logic [NS-1:0]  sleeping_q;
  logic [PW-1:0]  sleep_pin_q [NS];
  logic [CW-1:0]  cnt_q       [NS];

  logic           elite_present_q;
  logic           cur_valid_q;
  logic [SW-1:0]  cur_slot_q;
  logic [CW-1:0]  step_q;

  // Walk state
  logic [IW-1:0]  idx_q;
  logic           have_q;
  logic [IW-1:0]  best_q;
  logic [CW-1:0]  best_val_q;
  logic           woken_q;

  // Output register
  logic           sel_valid_q;
  logic [SW-1:0]  sel_slot_q;
  logic           sel_woken_q;

  // Request slot range check
  logic           slot_ok;
  logic [IW-1:0]  slot_idx;
  assign slot_ok  = ({1'b0, slot_q} < (SW + 1)'(NS));
  assign slot_idx = IW'(slot_q);

  // Examine the slot under the walk index
  logic           w_act, w_hit, w_elite, w_is_cur, w_take, pin_ok;
  logic [PW-1:0]  w_pin;
  logic [CW-1:0]  w_cnt;

  always_comb begin
    w_act    = active_q[idx_q];
    w_pin    = sleep_pin_q[idx_q];
    pin_ok   = ({1'b0, w_pin} < (PW + 1)'(NP));
    w_hit    = sleeping_q[idx_q] && pin_ok &&
               fired_q[w_pin[sps_pkg::PIN_IDX_W-1:0]];
    w_elite  = elite_q[idx_q];
    w_is_cur = cur_valid_q && (cur_slot_q == SW'(idx_q));
    w_cnt    = w_is_cur ? cnt_q[idx_q] : cnt_q[idx_q] + step_q;
    w_take   = !have_q || (w_cnt >= best_val_q);
  end

  assign stat_o.is_pick = (cmd_q == sps_pkg::CMD_PICK);
  assign stat_o.early   = w_act && (w_hit || w_elite);
  assign stat_o.last    = (idx_q == LAST_IDX);

  // Request capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q       <= sps_pkg::cmd_e'(command_i);
      slot_q      <= slot_i;
      elite_req_q <= elite_request_i;
      pin_q       <= pin_i;
      fired_q     <= wanted_mask_i[NP-1:0] & changed_mask_i[NP-1:0];
    end
  end

  // Slot table, walk and selection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q        <= '0;
      elite_q         <= '0;
      sleeping_q      <= '0;
      for (int i = 0; i < NS; i++) begin
        sleep_pin_q[i] <= '0;
        cnt_q[i]       <= '0;
      end
      elite_present_q <= 1'b0;
      cur_valid_q     <= 1'b0;
      cur_slot_q      <= '0;
      step_q          <= sps_pkg::STEP_RESET;
      idx_q           <= '0;
      have_q          <= 1'b0;
      best_q          <= '0;
      best_val_q      <= '0;
      woken_q         <= 1'b0;
      sel_valid_q     <= 1'b0;
      sel_slot_q      <= '0;
      sel_woken_q     <= 1'b0;
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;

      if (cmd_i.capture) begin
        idx_q   <= '0;
        have_q  <= 1'b0;
        woken_q <= 1'b0;
      end

      // Create, sleep and wake
      if (cmd_i.apply && slot_ok) begin
        case (cmd_q)
          sps_pkg::CMD_CREATE: begin
            active_q[slot_idx]    <= 1'b1;
            cnt_q[slot_idx]       <= '0;
            sleeping_q[slot_idx]  <= 1'b0;
            sleep_pin_q[slot_idx] <= '0;
            if (elite_req_q && !elite_present_q) begin
              elite_q[slot_idx] <= 1'b1;
              elite_present_q   <= 1'b1;
            end else begin
              elite_q[slot_idx] <= 1'b0;
            end
          end
          sps_pkg::CMD_SLEEP: begin
            sleeping_q[slot_idx]  <= 1'b1;
            sleep_pin_q[slot_idx] <= pin_q;
          end
          sps_pkg::CMD_WAKE: begin
            sleeping_q[slot_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      // One slot of a pick per cycle
      if (cmd_i.walk_step) begin
        idx_q <= idx_q + IW'(1);
        if (w_act) begin
          if (w_hit) begin
            sleeping_q[idx_q] <= 1'b0;
            cur_valid_q       <= 1'b1;
            cur_slot_q        <= SW'(idx_q);
            woken_q           <= 1'b1;
          end else if (w_elite) begin
            cur_valid_q <= 1'b1;
            cur_slot_q  <= SW'(idx_q);
          end else begin
            cnt_q[idx_q] <= w_cnt;
            if (w_take) begin
              have_q     <= 1'b1;
              best_q     <= idx_q;
              best_val_q <= w_cnt;
            end
          end
        end
      end

      // Starvation winner, or no current slot at all
      if (cmd_i.finish) begin
        if (have_q) begin
          cur_valid_q   <= 1'b1;
          cur_slot_q    <= SW'(best_q);
          cnt_q[best_q] <= '0;
        end else begin
          cur_valid_q <= 1'b0;
          cur_slot_q  <= '0;
        end
      end

      if (cmd_i.load_out) begin
        sel_valid_q <= cur_valid_q;
        sel_slot_q  <= cur_slot_q;
        sel_woken_q <= woken_q;
      end
    end
  end

  assign selected_valid_o = sel_valid_q;
  assign selected_slot_o  = sel_slot_q;
  assign woken_o          = sel_woken_q;

endmodule

@@ design/starvation_priority_scheduler.sv @@
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// cfg       cfg_we_i                     cfg_wdata_i (starvation step)
// request   in_valid_i / in_stall_o      command_i slot_i elite_request_i pin_i
//                                        wanted_mask_i changed_mask_i
// result    out_valid_o / out_stall_i    selected_valid_o selected_slot_o woken_o
//
// Create, sleep and wake go from accept through the start state to the done
// state, where the result loads. A pick walks the slot table one slot per
// cycle; a woken or elite slot ends the walk early. Reset clears the
// whole table at once. A held result does not block the next request; only
// the load of a new result waits for the output register to be free.

module starvation_priority_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sps_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sps_pkg::CMD_W-1:0]         command_i,
  input  logic [sps_pkg::SLOT_W-1:0]        slot_i,
  input  logic                              elite_request_i,
  input  logic [sps_pkg::PIN_W-1:0]         pin_i,
  input  logic [sps_pkg::MASK_W-1:0]        wanted_mask_i,
  input  logic [sps_pkg::MASK_W-1:0]        changed_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              selected_valid_o,
  output logic [sps_pkg::SLOT_W-1:0]        selected_slot_o,
  output logic                              woken_o
);

  sps_pkg::dp_cmd_t  dp_cmd;
  sps_pkg::dp_stat_t dp_stat;

  sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  sps_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .command_i        (command_i),
    .slot_i           (slot_i),
    .elite_request_i  (elite_request_i),
    .pin_i            (pin_i),
    .wanted_mask_i    (wanted_mask_i),
    .changed_mask_i   (changed_mask_i),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .selected_valid_o (selected_valid_o),
    .selected_slot_o  (selected_slot_o),
    .woken_o          (woken_o)
  );

endmodule
